FILE: rtl/core/ngga_pkg.sv
package ngga_pkg;

  // fixed byte codes of the sentence format
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CHAR_G      = 8'h47;  // 'G'
  localparam logic [7:0] CHAR_P      = 8'h50;  // 'P'
  localparam logic [7:0] CHAR_A      = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_1      = 8'h31;  // '1'
  localparam logic [7:0] CHAR_2      = 8'h32;  // '2'
  localparam logic [7:0] CHAR_3      = 8'h33;  // '3'
  localparam logic [7:0] CHAR_N      = 8'h4E;  // 'N'
  localparam logic [7:0] CHAR_S      = 8'h53;  // 'S'
  localparam logic [7:0] CHAR_E      = 8'h45;  // 'E'
  localparam logic [7:0] CHAR_W      = 8'h57;  // 'W'

  // header is exactly five characters
  localparam logic [3:0] HDR_LEN = 4'd5;

  // classified item held in the queue
  typedef struct packed {
    logic [7:0] data;
    logic       dollar;
    logic       comma;
  } item_t;

  // one result item
  typedef struct packed {
    logic [7:0] echo_byte;
    logic [3:0] field_number;
    logic [3:0] field_offset;
    logic       is_content;
    logic       sentence_done;
    logic       is_gga;
    logic       fix_valid;
    logic [7:0] quality_char;
    logic       lat_south;
    logic       lon_west;
    logic       truncated;
  } result_t;

  // expected header character at a given offset
  function automatic logic [7:0] hdr_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CHAR_G;
      3'd1:    c = CHAR_P;
      3'd2:    c = CHAR_G;
      3'd3:    c = CHAR_G;
      3'd4:    c = CHAR_A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/nmea_gga_field_parser_top.sv
// an accepted item is written into a queue slot, then parsed and registered in the result register
// one item per cycle while the output is not stalled, set by the parsing step in the back end
// a two-entry queue between front and back keeps input taking items while a result waits
// reset (rst_ni low, asynchronous): queue empty, no result valid, sentence state cleared
module nmea_gga_field_parser_top #(
  parameter int unsigned FIELD_COUNT  = 14,
  parameter int unsigned FIELD_CHARS  = 14,
  parameter int unsigned MAX_SENTENCE = 80
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] echo_byte_o,
  output logic [3:0] field_number_o,
  output logic [3:0] field_offset_o,
  output logic       is_content_o,
  output logic       sentence_done_o,
  output logic       is_gga_o,
  output logic       fix_valid_o,
  output logic [7:0] quality_char_o,
  output logic       lat_south_o,
  output logic       lon_west_o,
  output logic       truncated_o
);

  logic              head_valid;
  logic              pop;
  ngga_pkg::item_t   head;
  ngga_pkg::result_t res;

  // front: classify and queue items
  ngga_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // back: sentence parsing and result register
  ngga_back #(
    .FIELD_COUNT  (FIELD_COUNT),
    .FIELD_CHARS  (FIELD_CHARS),
    .MAX_SENTENCE (MAX_SENTENCE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  // result fields
  assign echo_byte_o     = res.echo_byte;
  assign field_number_o  = res.field_number;
  assign field_offset_o  = res.field_offset;
  assign is_content_o    = res.is_content;
  assign sentence_done_o = res.sentence_done;
  assign is_gga_o        = res.is_gga;
  assign fix_valid_o     = res.fix_valid;
  assign quality_char_o  = res.quality_char;
  assign lat_south_o     = res.lat_south;
  assign lon_west_o      = res.lon_west;
  assign truncated_o     = res.truncated;

endmodule

FILE: rtl/core/ngga_front.sv
module ngga_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  output logic                head_valid_o,
  output ngga_pkg::item_t     head_o,
  input  logic                pop_i
);

  ngga_pkg::item_t  slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push;
  ngga_pkg::item_t  item_in;

  // classify the incoming byte
  always_comb begin
    item_in.data   = rx_byte_i;
    item_in.dollar = (rx_byte_i == ngga_pkg::CHAR_DOLLAR);
    item_in.comma  = (rx_byte_i == ngga_pkg::CHAR_COMMA);
  end

  // two-entry queue control
  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

FILE: rtl/core/ngga_back.sv
module ngga_back #(
  parameter int unsigned FIELD_COUNT  = 14,
  parameter int unsigned FIELD_CHARS  = 14,
  parameter int unsigned MAX_SENTENCE = 80
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  ngga_pkg::item_t     head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ngga_pkg::result_t   res_o
);

  localparam logic [3:0] FieldCnt = 4'(FIELD_COUNT);
  localparam logic [3:0] FieldChr = 4'(FIELD_CHARS);
  localparam logic [6:0] MaxSent  = 7'(MAX_SENTENCE);

  logic [3:0] fc_q, fc_d;
  logic [3:0] oc_q, oc_d;
  logic [6:0] len_q, len_d;
  logic       hm_q, hm_d;
  logic       time_q, time_d;
  logic       lat_q, lat_d;
  logic       lon_q, lon_d;
  logic [7:0] latdir_q, latdir_d;
  logic [7:0] londir_q, londir_d;
  logic [7:0] qual_q, qual_d;
  logic       ovf_q, ovf_d;
  logic       out_valid_q;
  ngga_pkg::result_t res_q, res_d;

  logic [7:0] b;
  logic       gga, q_ok, ld_ok, od_ok;

  // take the next item whenever the output register is free or draining
  assign pop_o       = head_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign b           = head_i.data;

  // sentence verdict from collected state
  assign gga   = hm_q && (fc_q != 4'd0);
  assign q_ok  = (qual_q == ngga_pkg::CHAR_1) || (qual_q == ngga_pkg::CHAR_2) ||
                 (qual_q == ngga_pkg::CHAR_3);
  assign ld_ok = (latdir_q == ngga_pkg::CHAR_N) || (latdir_q == ngga_pkg::CHAR_S);
  assign od_ok = (londir_q == ngga_pkg::CHAR_E) || (londir_q == ngga_pkg::CHAR_W);

  // per-byte parsing step
  always_comb begin
    fc_d     = fc_q;
    oc_d     = oc_q;
    len_d    = len_q;
    hm_d     = hm_q;
    time_d   = time_q;
    lat_d    = lat_q;
    lon_d    = lon_q;
    latdir_d = latdir_q;
    londir_d = londir_q;
    qual_d   = qual_q;
    ovf_d    = ovf_q;
    res_d    = '0;
    res_d.echo_byte = b;

    if (head_i.dollar) begin
      // close the sentence and report its verdict
      res_d.sentence_done = 1'b1;
      res_d.is_gga        = gga;
      res_d.fix_valid     = gga && q_ok && time_q && lat_q && lon_q && ld_ok && od_ok;
      res_d.quality_char  = qual_q;
      res_d.lat_south     = (latdir_q == ngga_pkg::CHAR_S);
      res_d.lon_west      = (londir_q == ngga_pkg::CHAR_W);
      res_d.truncated     = ovf_q;
      fc_d     = 4'd0;
      oc_d     = 4'd0;
      len_d    = 7'd0;
      hm_d     = 1'b1;
      time_d   = 1'b0;
      lat_d    = 1'b0;
      lon_d    = 1'b0;
      latdir_d = 8'd0;
      londir_d = 8'd0;
      qual_d   = 8'd0;
      ovf_d    = 1'b0;
    end else if (len_q >= MaxSent) begin
      // sentence too long: drop the byte
      ovf_d              = 1'b1;
      res_d.field_number = FieldCnt;
    end else begin
      len_d              = len_q + 7'd1;
      res_d.field_number = fc_q;
      res_d.field_offset = oc_q;
      if (head_i.comma) begin
        // field boundary
        if (fc_q == 4'd0 && oc_q != ngga_pkg::HDR_LEN) begin
          hm_d = 1'b0;
        end
        if (fc_q < FieldCnt) begin
          fc_d = fc_q + 4'd1;
        end
        oc_d = 4'd0;
      end else begin
        res_d.is_content = 1'b1;
        if (fc_q < FieldCnt) begin
          if (oc_q >= FieldChr) begin
            ovf_d = 1'b1;
          end else begin
            // capture the fields that the verdict needs
            case (fc_q)
              4'd0: begin
                if (oc_q >= ngga_pkg::HDR_LEN || b != ngga_pkg::hdr_char(oc_q[2:0])) begin
                  hm_d = 1'b0;
                end
              end
              4'd1: time_d = 1'b1;
              4'd2: lat_d  = 1'b1;
              4'd3: begin
                if (oc_q == 4'd0) begin
                  latdir_d = b;
                end
              end
              4'd4: lon_d = 1'b1;
              4'd5: begin
                if (oc_q == 4'd0) begin
                  londir_d = b;
                end
              end
              4'd6: begin
                if (oc_q == 4'd0) begin
                  qual_d = b;
                end
              end
              default: ;
            endcase
            oc_d = oc_q + 4'd1;
          end
        end else if (oc_q < FieldChr) begin
          oc_d = oc_q + 4'd1;
        end
      end
    end
  end

  // sentence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q     <= 4'd0;
      oc_q     <= 4'd0;
      len_q    <= 7'd0;
      hm_q     <= 1'b1;
      time_q   <= 1'b0;
      lat_q    <= 1'b0;
      lon_q    <= 1'b0;
      latdir_q <= 8'd0;
      londir_q <= 8'd0;
      qual_q   <= 8'd0;
      ovf_q    <= 1'b0;
    end else if (pop_o) begin
      fc_q     <= fc_d;
      oc_q     <= oc_d;
      len_q    <= len_d;
      hm_q     <= hm_d;
      time_q   <= time_d;
      lat_q    <= lat_d;
      lon_q    <= lon_d;
      latdir_q <= latdir_d;
      londir_q <= londir_d;
      qual_q   <= qual_d;
      ovf_q    <= ovf_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: dv/tb_nmea_gga_field_parser_top.sv
`timescale 1ns / 100ps

module tb_nmea_gga_field_parser_top;

  localparam int unsigned FIELD_COUNT  = 14;
  localparam int unsigned FIELD_CHARS  = 14;
  localparam int unsigned MAX_SENTENCE = 80;

  localparam logic [39:0] GGA_HEADER = {ngga_pkg::CHAR_G, ngga_pkg::CHAR_P, ngga_pkg::CHAR_G,
                                        ngga_pkg::CHAR_G, ngga_pkg::CHAR_A};
  localparam logic [7:0]  CHAR_0     = 8'h30;
  localparam logic [7:0]  CHAR_DOT   = 8'h2E;
  localparam logic [7:0]  CHAR_STAR  = 8'h2A;

  localparam int PHASE_ITEMS  = 180;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;

  // sentence state tracker and store of expected byte reports
  class gga_byte_tracker;
    ngga_pkg::result_t byte_reports[$];
    int          fail_count;
    int unsigned field_idx;
    int unsigned char_idx;
    int unsigned taken_len;
    bit          header_ok;
    bit          time_present;
    bit          lat_present;
    bit          lon_present;
    bit          too_long;
    logic [7:0]  lat_hemi;
    logic [7:0]  lon_hemi;
    logic [7:0]  fix_quality;

    function new();
      fail_count = 0;
      start_sentence();
    endfunction

    function void start_sentence();
      field_idx    = 0;
      char_idx     = 0;
      taken_len    = 0;
      header_ok    = 1'b1;
      time_present = 1'b0;
      lat_present  = 1'b0;
      lon_present  = 1'b0;
      too_long     = 1'b0;
      lat_hemi     = '0;
      lon_hemi     = '0;
      fix_quality  = '0;
    endfunction

    // work out the report for one accepted item and advance the sentence state
    function void parse_byte(logic [7:0] b);
      ngga_pkg::result_t r;
      bit      gga;
      r = '0;
      r.echo_byte = b;
      if (b == ngga_pkg::CHAR_DOLLAR) begin
        // closing verdict on the sentence so far
        gga = header_ok && field_idx >= 1;
        r.sentence_done = 1'b1;
        r.is_gga        = gga;
        r.fix_valid     = gga && time_present && lat_present && lon_present
                          && (fix_quality == ngga_pkg::CHAR_1
                              || fix_quality == ngga_pkg::CHAR_2
                              || fix_quality == ngga_pkg::CHAR_3)
                          && (lat_hemi == ngga_pkg::CHAR_N || lat_hemi == ngga_pkg::CHAR_S)
                          && (lon_hemi == ngga_pkg::CHAR_E || lon_hemi == ngga_pkg::CHAR_W);
        r.quality_char  = fix_quality;
        r.lat_south     = (lat_hemi == ngga_pkg::CHAR_S);
        r.lon_west      = (lon_hemi == ngga_pkg::CHAR_W);
        r.truncated     = too_long;
        start_sentence();
      end else if (taken_len >= MAX_SENTENCE) begin
        // sentence full, byte dropped
        too_long = 1'b1;
        r.field_number = 4'(FIELD_COUNT);
      end else begin
        taken_len++;
        r.field_number = 4'(field_idx);
        r.field_offset = 4'(char_idx);
        if (b == ngga_pkg::CHAR_COMMA) begin
          if (field_idx == 0 && char_idx != ngga_pkg::HDR_LEN) header_ok = 1'b0;
          if (field_idx < FIELD_COUNT) field_idx++;
          char_idx = 0;
        end else begin
          r.is_content = 1'b1;
          if (field_idx >= FIELD_COUNT) begin
            if (char_idx < FIELD_CHARS) char_idx++;
          end else if (char_idx >= FIELD_CHARS) begin
            too_long = 1'b1;
          end else begin
            case (field_idx)
              0: begin
                if (char_idx >= ngga_pkg::HDR_LEN) header_ok = 1'b0;
                else if (b != GGA_HEADER[39 - 8 * char_idx -: 8]) header_ok = 1'b0;
              end
              1: time_present = 1'b1;
              2: lat_present = 1'b1;
              3: if (char_idx == 0) lat_hemi = b;
              4: lon_present = 1'b1;
              5: if (char_idx == 0) lon_hemi = b;
              6: if (char_idx == 0) fix_quality = b;
              default: ;
            endcase
            char_idx++;
          end
        end
      end
      byte_reports.push_back(r);
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        fail_count++;
      end
    endfunction

    // check one accepted result against the oldest expected report
    function void check_report(ngga_pkg::result_t got);
      ngga_pkg::result_t want;
      if (byte_reports.size() == 0) begin
        $error("echo_byte: expected nothing, got %0h", got.echo_byte);
        fail_count++;
        return;
      end
      want = byte_reports.pop_front();
      compare("echo_byte", want.echo_byte, got.echo_byte);
      compare("field_number", 8'(want.field_number), 8'(got.field_number));
      compare("field_offset", 8'(want.field_offset), 8'(got.field_offset));
      compare("is_content", 8'(want.is_content), 8'(got.is_content));
      compare("sentence_done", 8'(want.sentence_done), 8'(got.sentence_done));
      compare("is_gga", 8'(want.is_gga), 8'(got.is_gga));
      compare("fix_valid", 8'(want.fix_valid), 8'(got.fix_valid));
      compare("quality_char", want.quality_char, got.quality_char);
      compare("lat_south", 8'(want.lat_south), 8'(got.lat_south));
      compare("lon_west", 8'(want.lon_west), 8'(got.lon_west));
      compare("truncated", 8'(want.truncated), 8'(got.truncated));
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] echo_byte_o;
  logic [3:0] field_number_o;
  logic [3:0] field_offset_o;
  logic       is_content_o;
  logic       sentence_done_o;
  logic       is_gga_o;
  logic       fix_valid_o;
  logic [7:0] quality_char_o;
  logic       lat_south_o;
  logic       lon_west_o;
  logic       truncated_o;

  gga_byte_tracker tracker = new();
  logic [7:0]      sentence_q[$];
  int              bytes_sent;
  int              quiet_cycles;
  int              send_idle_pct;
  int              recv_idle_pct;
  bit              hold_request;

  nmea_gga_field_parser_top #(
    .FIELD_COUNT (FIELD_COUNT),
    .FIELD_CHARS (FIELD_CHARS),
    .MAX_SENTENCE(MAX_SENTENCE)
  ) DUT (.*);

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // accepted items in and out, plus watchdog on lack of progress
  always @(posedge clk_i) begin
    ngga_pkg::result_t seen;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.parse_byte(rx_byte_i);
      if (out_valid_o && !out_stall_i) begin
        seen = {echo_byte_o, field_number_o, field_offset_o, is_content_o,
                sentence_done_o, is_gga_o, fix_valid_o, quality_char_o,
                lat_south_o, lon_west_o, truncated_o};
        tracker.check_report(seen);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // receiver: random stalls, with one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // offer one item, idling at random first, and hold it until taken
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // sender pause until every expected report has come
  task automatic wait_for_reports();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.byte_reports.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] any_text_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == ngga_pkg::CHAR_DOLLAR || c == ngga_pkg::CHAR_COMMA) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] digit_char();
    if ($urandom_range(9) == 0) return CHAR_DOT;
    return 8'(CHAR_0 + $urandom_range(9));
  endfunction

  // empty now and then, otherwise 1 to hi characters
  function automatic int unsigned maybe_len(int unsigned hi);
    if ($urandom_range(9) == 0) return 0;
    return $urandom_range(hi, 1);
  endfunction

  function automatic void push_field(int unsigned len);
    sentence_q.push_back(ngga_pkg::CHAR_COMMA);
    repeat (len) sentence_q.push_back(digit_char());
  endfunction

  function automatic void push_direction(logic [7:0] one, logic [7:0] other);
    int unsigned pick;
    pick = $urandom_range(9);
    sentence_q.push_back(ngga_pkg::CHAR_COMMA);
    if (pick < 4) sentence_q.push_back(one);
    else if (pick < 8) sentence_q.push_back(other);
    else if (pick == 8) sentence_q.push_back(any_text_char());
  endfunction

  // one sentence: mostly gga shaped with random content, some noise
  task automatic send_sentence();
    int unsigned kind;
    int unsigned pick;
    sentence_q = {};
    kind = $urandom_range(99);
    if (kind < 20) begin
      // raw noise, commas and dollars included
      repeat ($urandom_range(30)) sentence_q.push_back(8'($urandom_range(255)));
    end else begin
      for (int i = 4; i >= 0; i--) sentence_q.push_back(GGA_HEADER[8 * i +: 8]);
      // header alone, never closed by a comma
      if (kind >= 25) begin
        case ($urandom_range(9))
          0: sentence_q[$urandom_range(4)] = any_text_char();
          1: void'(sentence_q.pop_back());
          2: sentence_q.push_back(digit_char());
          default: ;
        endcase
        push_field(maybe_len(6));
        // latitude, now and then longer than a field may be
        if ($urandom_range(9) == 0) push_field($urandom_range(FIELD_CHARS + 3, FIELD_CHARS + 1));
        else push_field(maybe_len(8));
        push_direction(ngga_pkg::CHAR_N, ngga_pkg::CHAR_S);
        push_field(maybe_len(9));
        push_direction(ngga_pkg::CHAR_E, ngga_pkg::CHAR_W);
        // fix quality
        sentence_q.push_back(ngga_pkg::CHAR_COMMA);
        pick = $urandom_range(9);
        if (pick < 8) sentence_q.push_back(8'(ngga_pkg::CHAR_1 + $urandom_range(2)));
        else if (pick == 8) sentence_q.push_back($urandom_range(1) ? CHAR_0 : any_text_char());
        if ($urandom_range(3) == 0) sentence_q.push_back(digit_char());
        // trailing fields: short, past the kept ones, or past the sentence limit
        pick = $urandom_range(9);
        if (pick == 0) begin
          repeat (FIELD_COUNT - 7) push_field($urandom_range(1));
          push_field(FIELD_CHARS + 2);
          push_field($urandom_range(3));
        end else if (pick == 1) begin
          repeat (6) push_field(12);
        end else begin
          repeat ($urandom_range(7)) push_field($urandom_range(4));
        end
        if ($urandom_range(1)) begin
          sentence_q.push_back(CHAR_STAR);
          sentence_q.push_back(digit_char());
          sentence_q.push_back(digit_char());
        end
      end
    end
    foreach (sentence_q[i]) send_byte(sentence_q[i]);
    send_byte(ngga_pkg::CHAR_DOLLAR);
  endtask

  // stimulus
  initial begin
    string fixed_sentence;
    fixed_sentence = "GPGGA,1,2,S,3,W,2";
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    rx_byte_i    <= '0;
    bytes_sent    = 0;
    quiet_cycles  = 0;
    hold_request  = 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 55;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty sentence, a valid south-west fix, extreme bytes
    send_byte(ngga_pkg::CHAR_DOLLAR);
    for (int i = 0; i < fixed_sentence.len(); i++) send_byte(fixed_sentence[i]);
    send_byte(ngga_pkg::CHAR_DOLLAR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ngga_pkg::CHAR_COMMA);
    send_byte(ngga_pkg::CHAR_DOLLAR);
    wait_for_reports();

    // random sentences in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 55;
          hold_request  = 1'b1;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      bytes_sent = 0;
      while (bytes_sent < PHASE_ITEMS) send_sentence();
      wait_for_reports();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
